// ----- src/olte_pkg.sv -----
// ============================================================================
// olte_pkg
// Shared types and constants for the ordered list table engine.
// ============================================================================
`default_nettype none

package olte_pkg;

   // default geometry
   localparam int DEPTH_DEFAULT      = 256;
   localparam int WORD_WIDTH_DEFAULT = 32;

   // fixed field widths of the stream payloads
   localparam int KIND_W      = 3;
   localparam int POSITION_W  = 8;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 9;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 40;  // position + value
   localparam int RSP_DATA_W  = 56;  // 51 bits used, padded to whole bytes
   localparam int RSP_PAD_W   = RSP_DATA_W - VALUE_W - POSITION_W - COUNT_OUT_W - STATUS_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_GET    = 3'd0,
      KIND_SET    = 3'd1,
      KIND_APPEND = 3'd2,
      KIND_INSERT = 3'd3,
      KIND_REMOVE = 3'd4,
      KIND_FIND   = 3'd5,
      KIND_ERASE  = 3'd6,
      KIND_CLEAR  = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_POS   = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_GET_WAIT   = 3'd1,
      ST_SHIFT_UP   = 3'd2,
      ST_INS_LAST   = 3'd3,
      ST_RM_FIRST   = 3'd4,
      ST_SHIFT_DOWN = 3'd5,
      ST_SCAN       = 3'd6,
      ST_FINISH     = 3'd7
   } state_type;

endpackage : olte_pkg

`default_nettype wire

// ----- src/olte_ram.sv -----
// ============================================================================
// olte_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module olte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : olte_ram

`default_nettype wire

// ----- src/ordered_list_table_engine_core.sv -----
// ============================================================================
// ordered_list_table_engine_core
// Fixed-capacity ordered list of words held in one synchronous RAM, with
// get / set / append / insert / remove / find / erase / clear requests.
// ============================================================================
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+-------------
//  req_     | in  | position[7:0], value[39:8]                 | kind[2:0]
//  rsp_     | out | read_value[31:0], found_position[39:32],   | -
//           |     | entry_count[48:40], status[50:49], zero pad|
//
//  One request is worked at a time; the single RAM port pair sets the pace.
//  Set, append, clear and rejected requests finish without a shift; get reads
//  one entry; insert moves the entries from the top down to the position up
//  one slot first, or writes directly at the end of the list; remove moves
//  the entries above the position down; find scans from index 0 up to the
//  first match; erase scans up to the match, then shifts.
//  The next request is taken while a result still waits on rsp_.
//  Synchronous active-high reset empties the list; RAM contents are not cleared.
//
`default_nettype none

module ordered_list_table_engine_core
   import olte_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // position[7:0], value[39:8]
   input  wire logic [KIND_W-1:0]     req_tuser,   // kind[2:0]

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata    // read_value, found_position,
                                                   // entry_count, status, pad
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

   // ---------------------------------------------------------------- state
   state_type              state_ff,   state_in;
   logic [CW-1:0]          count_ff,   count_in;
   logic [CW-1:0]          ptr_ff,     ptr_in;     // scan index / shift destination
   logic [CW-1:0]          last_ff,    last_in;    // last index to move down
   logic [CW-1:0]          pos_ff,     pos_in;
   logic [WORD_WIDTH-1:0]  word_ff,    word_in;
   kind_type               kind_ff,    kind_in;
   logic [WORD_WIDTH-1:0]  rd_word_ff, rd_word_in;
   logic [POSITION_W-1:0]  fpos_ff,    fpos_in;
   status_type             status_ff,  status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff,  rsp_data_in;

   // ---------------------------------------------------------------- RAM port
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [WORD_WIDTH-1:0]  mem_wdata;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;
   logic [WORD_WIDTH-1:0]  mem_rdata;

   olte_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---------------------------------------------------------------- request decode
   logic                  req_fire;
   kind_type              req_kind;
   logic [POSITION_W-1:0] req_pos;
   logic [WORD_WIDTH-1:0] req_word;
   logic [CMPW-1:0]       req_pos_ext;
   logic [CMPW-1:0]       count_ext;
   logic                  pos_lt_count;
   logic                  pos_le_count;
   logic                  list_full;
   logic                  list_empty;
   logic [CW-1:0]         count_dec;
   logic [CW-1:0]         ptr_inc;
   logic [CW-1:0]         ptr_dec;
   logic                  scan_hit;
   logic                  out_free;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_kind     = kind_type'(req_tuser);
   assign req_pos      = req_tdata[POSITION_W-1:0];
   // value keeps only its low WORD_WIDTH bits (zero-extended when wider)
   assign req_word     = WORD_WIDTH'(req_tdata[POSITION_W +: VALUE_W]);
   assign req_pos_ext  = CMPW'(req_pos);
   assign count_ext    = CMPW'(count_ff);
   assign pos_lt_count = (req_pos_ext < count_ext);
   assign pos_le_count = (req_pos_ext <= count_ext);
   assign list_full    = (count_ff == CW'(DEPTH));
   assign list_empty   = (count_ff == '0);
   assign count_dec    = count_ff - CW'(1);
   assign ptr_inc      = ptr_ff + CW'(1);
   assign ptr_dec      = ptr_ff - CW'(1);
   assign scan_hit     = (mem_rdata == word_ff);
   assign out_free     = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_GET:    state_in = pos_lt_count ? ST_GET_WAIT : ST_FINISH;
                  KIND_INSERT: state_in = (pos_lt_count && !list_full) ? ST_SHIFT_UP
                                                                        : ST_FINISH;
                  KIND_REMOVE: state_in = pos_lt_count ? ST_RM_FIRST : ST_FINISH;
                  KIND_FIND,
                  KIND_ERASE:  state_in = list_empty ? ST_FINISH : ST_SCAN;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_GET_WAIT:   state_in = ST_FINISH;
         ST_SHIFT_UP:   state_in = (ptr_dec > pos_ff) ? ST_SHIFT_UP : ST_INS_LAST;
         ST_INS_LAST:   state_in = ST_FINISH;
         ST_RM_FIRST:   state_in = (ptr_ff < last_ff) ? ST_SHIFT_DOWN : ST_FINISH;
         ST_SHIFT_DOWN: state_in = (ptr_inc < last_ff) ? ST_SHIFT_DOWN : ST_FINISH;
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = (kind_ff == KIND_ERASE && ptr_ff < count_dec) ? ST_SHIFT_DOWN
                                                                         : ST_FINISH;
            end else begin
               state_in = (ptr_inc < count_ff) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_FINISH:     state_in = out_free ? ST_IDLE : ST_FINISH;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath / RAM control
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      kind_in      = kind_ff;
      rd_word_in   = rd_word_ff;
      fpos_in      = fpos_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in    = req_kind;
               word_in    = req_word;
               pos_in     = CW'(req_pos);
               rd_word_in = '0;
               fpos_in    = '0;
               status_in  = STATUS_OK;
               case (req_kind)
                  KIND_GET: begin
                     if (pos_lt_count) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(req_pos);
                     end else begin
                        status_in = STATUS_BAD_POS;
                     end
                  end
                  KIND_SET: begin
                     if (pos_lt_count) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_pos);
                        mem_wdata = req_word;
                     end else begin
                        status_in = STATUS_BAD_POS;
                     end
                  end
                  KIND_APPEND: begin
                     if (list_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_word;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  KIND_INSERT: begin
                     // position is checked before fullness
                     if (!pos_le_count) begin
                        status_in = STATUS_BAD_POS;
                     end else if (list_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        if (pos_lt_count) begin
                           // move top entry first, walking down to the position
                           mem_re    = 1'b1;
                           mem_raddr = count_dec[AW-1:0];
                           ptr_in    = count_ff;
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = AW'(req_pos);
                           mem_wdata = req_word;
                        end
                     end
                  end
                  KIND_REMOVE: begin
                     if (pos_lt_count) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(req_pos);
                        ptr_in    = CW'(req_pos);
                        last_in   = count_dec;
                        count_in  = count_dec;
                     end else begin
                        status_in = STATUS_BAD_POS;
                     end
                  end
                  KIND_FIND,
                  KIND_ERASE: begin
                     if (list_empty) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        ptr_in    = '0;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_GET_WAIT: begin
            rd_word_in = mem_rdata;
         end

         ST_SHIFT_UP: begin
            // write entry read last cycle one slot up; fetch the next lower one
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            ptr_in    = ptr_dec;
            if (ptr_dec > pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_dec - CW'(1));
            end
         end

         ST_INS_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = word_ff;
         end

         ST_RM_FIRST: begin
            rd_word_in = mem_rdata;
            if (ptr_ff < last_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_inc[AW-1:0];
            end
         end

         ST_SHIFT_DOWN: begin
            // write entry read last cycle one slot down; fetch the next higher one
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            mem_wdata = mem_rdata;
            ptr_in    = ptr_inc;
            if (ptr_inc < last_ff) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_inc + CW'(1));
            end
         end

         ST_SCAN: begin
            if (scan_hit) begin
               if (kind_ff == KIND_FIND) begin
                  fpos_in = POSITION_W'(ptr_ff);
               end else begin
                  // erase: close the gap at the match, ptr stays as destination
                  last_in  = count_dec;
                  count_in = count_dec;
                  if (ptr_ff < count_dec) begin
                     mem_re    = 1'b1;
                     mem_raddr = ptr_inc[AW-1:0];
                  end
               end
            end else if (ptr_inc < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_inc[AW-1:0];
               ptr_in    = ptr_inc;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD_W'(0), status_ff, COUNT_OUT_W'(count_ff),
                               fpos_ff, VALUE_W'(rd_word_ff)};
            end
         end

         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      kind_ff     <= kind_in;
      rd_word_ff  <= rd_word_in;
      fpos_ff     <= fpos_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : ordered_list_table_engine_core

`default_nettype wire
